/* hdl/assert_macros.svh */
// Assertion macros shared by the response line classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define RLC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under the asynchronous reset.
`define RLC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rlc_pkg.sv */
// Package with keyword tables, response codes and shared types of the line classifier.
package rlc_pkg;

	localparam int RLC_MAX_LINE = 64;
	localparam int NUM_KEYS = 14;
	localparam int PREFIX_LEN = 6;
	localparam int POS_W = 9;
	localparam int KEY_BITS = 256;

	typedef enum logic [3:0] {
		CODE_OK = 4'd0,
		CODE_BAD_PARAM = 4'd1,
		CODE_ACCEPTED = 4'd2,
		CODE_DENIED = 4'd3,
		CODE_NO_NETWORK = 4'd4,
		CODE_NO_CHANNEL = 4'd5,
		CODE_SILENT = 4'd6,
		CODE_FRAME_COUNTER = 4'd7,
		CODE_BUSY = 4'd8,
		CODE_PAUSED = 4'd9,
		CODE_BAD_DATA_LEN = 4'd10,
		CODE_TX_DONE = 4'd11,
		CODE_MAC_RX = 4'd12,
		CODE_MAC_ERR = 4'd13,
		CODE_NONE = 4'd14
	} rlc_code_t;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	typedef logic [NUM_KEYS-1:0] key_mask_t;

	typedef struct packed {
		key_mask_t alive;
		logic text_ended;
	} line_state_t;

	localparam int unsigned KEY_LEN [NUM_KEYS] = '{
		2, 13, 8, 6, 10, 10, 6, 31, 4, 10, 16, 9, 6, 7
	};

	localparam logic [KEY_BITS-1:0] KEY_TEXT [NUM_KEYS] = '{
		KEY_BITS'("ok"),
		KEY_BITS'({"invalid", "_param"}),
		KEY_BITS'("accepted"),
		KEY_BITS'("denied"),
		KEY_BITS'({"not", "_joined"}),
		KEY_BITS'({"no_free", "_ch"}),
		KEY_BITS'("silent"),
		KEY_BITS'({"frame_counter", "_err_rejoin_needed"}),
		KEY_BITS'("busy"),
		KEY_BITS'({"mac", "_paused"}),
		KEY_BITS'({"invalid", "_data_len"}),
		KEY_BITS'({"mac_tx", "_ok"}),
		KEY_BITS'("mac_rx"),
		KEY_BITS'("mac_err")
	};

	// Character of keyword k at position pos, zero past the end of the keyword.
	function automatic logic [7:0] key_char(input int k, input logic [POS_W-1:0] pos);
		int unsigned p;
		int unsigned len;
		logic [7:0] ch;
		p = 32'(pos);
		len = KEY_LEN[k];
		ch = CHAR_NUL;
		if (p < len) begin
			ch = KEY_TEXT[k][8*(len-1-p) +: 8];
		end
		return ch;
	endfunction

endpackage

/* hdl/rlc_if.sv */
// Valid/ready stream interfaces for received bytes and classified responses.
interface rlc_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rlc_resp_if;
	logic valid;
	logic ready;
	logic [3:0] response_code;
	logic [6:0] line_length;

	modport source (output valid, output response_code, output line_length, input ready);
	modport sink (input valid, input response_code, input line_length, output ready);
endinterface

/* hdl/rlc_match.sv */
// Keyword matcher: next keyword mask for one character and the response code of the line.
module rlc_match #(
	parameter int MAX_LINE = rlc_pkg::RLC_MAX_LINE
) (
	input logic [rlc_pkg::POS_W-1:0] pos,
	input logic [7:0] rx_byte,
	input rlc_pkg::line_state_t cur,
	output rlc_pkg::line_state_t nxt,
	output rlc_pkg::rlc_code_t code
);
	import rlc_pkg::*;

	logic [POS_W-1:0] eff;
	key_mask_t hit;

	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (k == int'(CODE_MAC_RX)) begin
				nxt.alive[k] = cur.alive[k] &&
					((32'(pos) >= PREFIX_LEN) || (key_char(k, pos) == rx_byte));
			end else begin
				nxt.alive[k] = cur.alive[k] && (key_char(k, pos) == rx_byte);
			end
		end
		nxt.text_ended = cur.text_ended || (rx_byte == CHAR_NUL);
	end

	always_comb begin
		eff = pos;
		if (!cur.text_ended && (32'(pos) > MAX_LINE - 1)) begin
			eff = POS_W'(MAX_LINE - 1);
		end
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (k == int'(CODE_MAC_RX)) begin
				hit[k] = cur.alive[k] && (cur.text_ended || (32'(eff) >= PREFIX_LEN));
			end else begin
				hit[k] = cur.alive[k] && (cur.text_ended || (32'(eff) == KEY_LEN[k]));
			end
		end
		code = CODE_NONE;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				code = rlc_code_t'(4'(k));
			end
		end
	end

endmodule

/* hdl/modem_response_line_classifier_core.sv */
// Top level of the modem response line classifier: input register, line state and result register.
//
//   channel | direction | payload                     | transfer when
//   rx      | in        | rx_byte[7:0]                | rx.valid && rx.ready
//   resp    | out       | response_code[3:0],         | resp.valid && resp.ready
//           |           | line_length[6:0]            |
//
// A line end byte sits in the input register after its transfer; its result is written into
// the result register once that register is free. One byte is taken every cycle unless a
// line end byte is held; the line state is fed back through the combinational matcher.
// Reset clears the line state and both valid flags. While a result waits, a line end byte of
// a non-empty line stays in the input register; input transfers stop until the result is taken.
module modem_response_line_classifier_core #(
	parameter int MAX_LINE = rlc_pkg::RLC_MAX_LINE
) (
	input logic clk,
	input logic arst_n,
	rlc_byte_if.sink rx,
	rlc_resp_if.source resp
);
	import rlc_pkg::*;

	`include "assert_macros.svh"

	localparam int CW = $clog2(MAX_LINE + 1);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic [CW-1:0] count_q;
	line_state_t line_q;
	logic out_valid_q;
	rlc_code_t code_q;
	logic [6:0] length_q;

	line_state_t line_nxt;
	rlc_code_t code;
	logic eol;
	logic emit;
	logic out_free;
	logic s1_move;
	logic s1_fire;

	rlc_match #(.MAX_LINE(MAX_LINE)) u_match (
		.pos(POS_W'(count_q)),
		.rx_byte(byte_s1),
		.cur(line_q),
		.nxt(line_nxt),
		.code(code)
	);

	assign eol = (byte_s1 == CHAR_LF) || (byte_s1 == CHAR_CR);
	assign emit = valid_s1 && eol && (count_q != '0);
	assign out_free = !out_valid_q || resp.ready;
	assign s1_move = !emit || out_free;
	assign s1_fire = valid_s1 && s1_move;
	assign rx.ready = !valid_s1 || s1_move;

	assign resp.valid = out_valid_q;
	assign resp.response_code = code_q;
	assign resp.line_length = length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			line_q.alive <= '1;
			line_q.text_ended <= 1'b0;
		end else if (s1_fire) begin
			if (eol) begin
				if (count_q != '0) begin
					count_q <= '0;
					line_q.alive <= '1;
					line_q.text_ended <= 1'b0;
				end
			end else if (32'(count_q) < MAX_LINE) begin
				if (!line_q.text_ended && (32'(count_q) < MAX_LINE - 1)) begin
					line_q <= line_nxt;
				end
				count_q <= CW'(count_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (resp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			code_q <= code;
			length_q <= 7'(count_q);
		end
	end

	`RLC_ASSERT_IMP(a_count_limit, clk, arst_n, 1'b1, 32'(count_q) <= MAX_LINE, "line count above limit")
	`RLC_ASSERT_IMP(a_emit_nonempty, clk, arst_n, emit && out_free, count_q != '0, "result for empty line")
	`RLC_ASSERT_NXT(a_clear_after, clk, arst_n, emit && out_free, count_q == '0 && out_valid_q, "line not cleared")

endmodule

/* tb/tb.sv */
// Testbench for the modem response line classifier: random byte stream, predictor and checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rlc_pkg::*;

	localparam int LINE_LIMIT = RLC_MAX_LINE;
	localparam int RANDOM_ITEMS = 1850;
	localparam int TAIL_ITEMS = 150;
	localparam int HOLD_AFTER = 700;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic drain;
		logic [7:0] value;
	} plan_item_t;

	typedef struct packed {
		rlc_code_t code;
		logic [6:0] length;
	} line_result_t;

	string kw_text [NUM_KEYS] = '{
		"ok", {string'("invalid"), "_param"}, "accepted", "denied",
		{string'("not"), "_joined"}, {string'("no_free"), "_ch"}, "silent",
		{string'("frame_counter"), "_err_rejoin_needed"}, "busy",
		{string'("mac"), "_paused"}, {string'("invalid"), "_data_len"},
		{string'("mac_tx"), "_ok"}, "mac_rx", "mac_err"
	};

	logic clk;
	logic arst_n;

	rlc_byte_if rx_ch ();
	rlc_resp_if resp_ch ();

	modem_response_line_classifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.resp(resp_ch)
	);

	plan_item_t byte_plan [$];
	line_result_t expected_lines [$];
	bit drain_next;
	int errors;

	logic exp_empty;
	logic tail_phase;
	logic resp_hold;
	int sent_cnt;

	int unsigned line_chars;
	logic [NUM_KEYS-1:0] keys_live;
	bit nul_seen;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic clear_line();
		line_chars = 0;
		keys_live = '1;
		nul_seen = 1'b0;
	endtask

	function automatic bit key_survives(int k, int unsigned pos, logic [7:0] c);
		int unsigned len;
		len = kw_text[k].len();
		if (k == int'(CODE_MAC_RX)) begin
			return pos >= PREFIX_LEN || (c != CHAR_NUL && 8'(kw_text[k][pos]) == c);
		end
		if (c == CHAR_NUL) begin
			return len == pos;
		end
		return pos < len && 8'(kw_text[k][pos]) == c;
	endfunction

	function automatic rlc_code_t line_code();
		int unsigned eff;
		eff = line_chars;
		if (!nul_seen && eff > LINE_LIMIT - 1) begin
			eff = LINE_LIMIT - 1;
		end
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (keys_live[k]) begin
				if (nul_seen) begin
					return rlc_code_t'(k);
				end
				if (k == int'(CODE_MAC_RX)) begin
					if (eff >= PREFIX_LEN) begin
						return CODE_MAC_RX;
					end
				end else if (kw_text[k].len() == eff) begin
					return rlc_code_t'(k);
				end
			end
		end
		return CODE_NONE;
	endfunction

	task automatic frame_byte(input logic [7:0] c);
		line_result_t r;
		if (c == CHAR_LF || c == CHAR_CR) begin
			if (line_chars != 0) begin
				r.code = line_code();
				r.length = 7'(line_chars);
				expected_lines.push_back(r);
				clear_line();
			end
		end else if (line_chars < LINE_LIMIT) begin
			if (!nul_seen && line_chars < LINE_LIMIT - 1) begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					if (keys_live[k] && !key_survives(k, line_chars, c)) begin
						keys_live[k] = 1'b0;
					end
				end
				if (c == CHAR_NUL) begin
					nul_seen = 1'b1;
				end
			end
			line_chars++;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		plan_item_t it;
		it.drain = drain_next;
		it.value = b;
		byte_plan.push_back(it);
		drain_next = 1'b0;
	endtask

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		if ($urandom_range(0, 3) != 0) begin
			c = 8'($urandom_range(32, 126));
		end else begin
			do c = 8'($urandom_range(0, 255));
			while (c == CHAR_LF || c == CHAR_CR);
		end
		return c;
	endfunction

	task automatic push_key(input int k, input int n);
		for (int i = 0; i < n; i++) begin
			push_byte(8'(kw_text[k][i]));
		end
	endtask

	task automatic push_text(input int n);
		for (int i = 0; i < n; i++) begin
			push_byte(text_char());
		end
	endtask

	task automatic push_line_end();
		int sel;
		sel = $urandom_range(0, 2);
		if (sel == 0) begin
			push_byte(CHAR_CR);
		end else if (sel == 1) begin
			push_byte(CHAR_LF);
		end else begin
			push_byte(CHAR_CR);
			push_byte(CHAR_LF);
		end
	endtask

	task automatic add_random_line();
		int kind;
		int k;
		int len;
		int pos;
		kind = $urandom_range(0, 99);
		k = $urandom_range(0, NUM_KEYS - 1);
		len = kw_text[k].len();
		if ($urandom_range(0, 7) == 0) begin
			drain_next = 1'b1;
		end
		if ($urandom_range(0, 4) == 0) begin
			push_line_end();
		end
		if (kind < 35) begin
			push_key(k, len);
		end else if (kind < 45) begin
			pos = $urandom_range(0, len - 1);
			for (int i = 0; i < len; i++) begin
				push_byte(i == pos ? text_char() : 8'(kw_text[k][i]));
			end
		end else if (kind < 52) begin
			push_key(k, $urandom_range(1, len - 1));
		end else if (kind < 60) begin
			push_key(k, len);
			push_text($urandom_range(1, 5));
		end else if (kind < 70) begin
			push_key(int'(CODE_MAC_RX), PREFIX_LEN);
			push_text($urandom_range(0, 70));
		end else if (kind < 78) begin
			push_key(k, $urandom_range(0, len));
			push_byte(CHAR_NUL);
			push_text($urandom_range(0, 10));
		end else if (kind < 88) begin
			if ($urandom_range(0, 1) == 0) begin
				push_key(k, len);
			end
			push_text($urandom_range(55, 80));
		end else begin
			for (int i = $urandom_range(1, 20); i > 0; i--) begin
				push_byte(8'($urandom_range(0, 255)));
			end
		end
		push_line_end();
	endtask

	task automatic build_plan();
		push_byte(CHAR_CR);
		push_byte(CHAR_LF);
		push_key(int'(CODE_OK), 2);
		push_byte(CHAR_LF);
		push_key(int'(CODE_MAC_RX), PREFIX_LEN);
		push_byte(CHAR_CR);
		push_byte(CHAR_NUL);
		push_byte(8'h6B);
		push_byte(CHAR_CR);
		push_key(int'(CODE_OK), 2);
		push_byte(CHAR_NUL);
		push_byte(8'hFF);
		push_byte(CHAR_LF);
		push_byte(8'hFF);
		push_byte(CHAR_CR);
		drain_next = 1'b1;
		while (byte_plan.size() < RANDOM_ITEMS + 20) begin
			add_random_line();
		end
	endtask

	// Byte driver.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= 8'h00;
			sent_cnt <= 0;
			tail_phase <= 1'b0;
			send_gap = 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				sent_cnt <= sent_cnt + 1;
			end
			tail_phase <= byte_plan.size() < TAIL_ITEMS;
			if (!rx_ch.valid || rx_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					rx_ch.valid <= 1'b0;
				end else if (byte_plan.size() == 0) begin
					rx_ch.valid <= 1'b0;
				end else if (byte_plan[0].drain && (rx_ch.valid || !exp_empty)) begin
					rx_ch.valid <= 1'b0;
				end else if (!tail_phase && !resp_hold && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 10);
					rx_ch.valid <= 1'b0;
				end else begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= byte_plan[0].value;
					byte_plan.pop_front();
				end
			end
		end
	end

	// Result receiver with random stalls and one long hold-off.
	int sink_gap;
	int hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_ch.ready <= 1'b0;
			resp_hold <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else if (!hold_done && sent_cnt >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			resp_hold <= 1'b1;
			resp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			resp_ch.ready <= 1'b0;
			if (hold_left == 0) begin
				resp_hold <= 1'b0;
			end
		end else if (sink_gap > 0) begin
			sink_gap--;
			resp_ch.ready <= 1'b0;
		end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(0, 10);
			resp_ch.ready <= 1'b0;
		end else begin
			resp_ch.ready <= 1'b1;
		end
	end

	// Monitor: checks each result transfer, then predicts from each byte transfer.
	line_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			expected_lines.delete();
			exp_empty <= 1'b1;
		end else begin
			if (resp_ch.valid && resp_ch.ready) begin
				if (expected_lines.size() == 0) begin
					$display("%0t: unexpected result: code %0d length %0d", $time,
						resp_ch.response_code, resp_ch.line_length);
					errors++;
				end else begin
					want = expected_lines.pop_front();
					if (resp_ch.response_code !== want.code ||
						resp_ch.line_length !== want.length) begin
						$display("%0t: mismatch: expected code %0d length %0d, actual code %0d length %0d",
							$time, want.code, want.length,
							resp_ch.response_code, resp_ch.line_length);
						errors++;
					end
				end
			end
			if (rx_ch.valid && rx_ch.ready) begin
				frame_byte(rx_ch.rx_byte);
			end
			exp_empty <= expected_lines.size() == 0;
		end
	end

	initial begin
		arst_n = 1'b0;
		errors = 0;
		drain_next = 1'b0;
		build_plan();
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		while (byte_plan.size() != 0 || rx_ch.valid || expected_lines.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout with %0d results outstanding", $time, expected_lines.size());
		$display("tb failed");
		$finish;
	end

endmodule
